@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the RTL files that carry concurrent checks.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);
// Condition must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

@@ hw/rtl/hdsr_pkg.sv @@
// Widths, constants, types and the percent table for the HSV shading block.
// No dependencies; every other RTL file of the block imports this package.
package hdsr_pkg;

    localparam int FRAC_BITS = 16;
    localparam int V_W       = FRAC_BITS + 1;   // holds 0 .. 1.0 inclusive
    localparam int HUE_W     = 9;
    localparam int PCT_W     = 7;
    localparam int DIST_W    = 8;
    localparam int CFG_W     = 8;
    localparam int SPAN_W    = CFG_W + 1;       // L+1 reaches 256
    localparam int NUM_W     = V_W + SPAN_W;    // dimming dividend
    localparam int K_W       = 6;               // 0 .. 60
    localparam int P_W       = V_W + K_W;       // C * k
    localparam int RECIP_W   = P_W - 5;         // 2^P_W / 60 < 2^(P_W-5)
    localparam int RGB_W     = 16;
    localparam int CH8_W     = 8;

    localparam int FIFO_AW    = 2;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;

    localparam int PCT_ENTRIES = 1 << PCT_W;
    localparam int PCT_FULL    = 100;
    localparam int SECTOR_DEG  = 60;
    localparam int HUE_FULL    = 360;

    localparam logic [CFG_W-1:0] MAX_RAY_RESET = CFG_W'(20);

    localparam logic [HUE_W-1:0] HUE_360 = HUE_W'(HUE_FULL);
    localparam logic [HUE_W-1:0] HUE_60  = HUE_W'(SECTOR_DEG);
    localparam logic [HUE_W-1:0] HUE_120 = HUE_W'(2 * SECTOR_DEG);
    localparam logic [HUE_W-1:0] HUE_180 = HUE_W'(3 * SECTOR_DEG);
    localparam logic [HUE_W-1:0] HUE_240 = HUE_W'(4 * SECTOR_DEG);
    localparam logic [HUE_W-1:0] HUE_300 = HUE_W'(5 * SECTOR_DEG);

    // Reciprocal of 60 scaled by 2^P_W, rounded down.
    localparam longint RECIP_L = (longint'(1) << P_W) / SECTOR_DEG;
    localparam logic [RECIP_W-1:0] RECIP60 = RECIP_W'(RECIP_L);
    localparam logic [P_W-1:0]     SIXTY_P = P_W'(SECTOR_DEG);

    typedef enum logic [2:0] {
        SEC_R2Y,
        SEC_Y2G,
        SEC_G2C,
        SEC_C2B,
        SEC_B2M,
        SEC_M2R
    } t_sector;

    typedef struct packed {
        logic [V_W-1:0] s;
        t_sector        sector;
        logic [K_W-1:0] k;
    } t_side;

    typedef struct packed {
        logic [NUM_W-1:0]  num;
        logic [SPAN_W-1:0] span;
        t_side             side;
    } t_work;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    // Percent to fixed point, floor(p * 2^FRAC_BITS / 100), inputs above 100 clamp.
    typedef logic [V_W-1:0] t_pct_lut [PCT_ENTRIES];

    function automatic t_pct_lut build_pct_lut();
        t_pct_lut t;
        longint   p;
        for (int i = 0; i < PCT_ENTRIES; i++) begin
            p = (i > PCT_FULL) ? longint'(PCT_FULL) : longint'(i);
            t[i] = V_W'((p << FRAC_BITS) / PCT_FULL);
        end
        return t;
    endfunction

    localparam t_pct_lut PCT_LUT = build_pct_lut();

endpackage

@@ hw/rtl/hdsr_fifo.sv @@
// Four-entry work queue between the classifying front and the arithmetic back.
// Depends on hdsr_pkg for the work item type and the queue depth.
module hdsr_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  hdsr_pkg::t_work     i_data,
    input  logic                i_pop,
    output hdsr_pkg::t_work     o_data,
    output hdsr_pkg::t_fifo_stat o_stat
);
    import hdsr_pkg::*;

    t_work                r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr;
    logic [FIFO_AW-1:0]   r_rd_ptr;
    logic [FIFO_AW:0]     r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

@@ hw/rtl/hdsr_front.sv @@
// Front end: accepts items, reduces hue, looks up s and v, builds the dimming dividend.
// Depends on hdsr_pkg; also finds sector and k, and pushes finished work items into hdsr_fifo.
module hdsr_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [hdsr_pkg::HUE_W-1:0]   i_hue,
    input  logic [hdsr_pkg::PCT_W-1:0]   i_saturation,
    input  logic [hdsr_pkg::PCT_W-1:0]   i_brightness,
    input  logic [hdsr_pkg::DIST_W-1:0]  i_distance,
    input  logic [hdsr_pkg::CFG_W-1:0]   i_max_ray_length,
    input  hdsr_pkg::t_fifo_stat         i_fifo_stat,
    output logic                         o_push,
    output hdsr_pkg::t_work              o_work
);
    import hdsr_pkg::*;

    logic en;
    logic accept;

    // Stage one registers.
    logic                r1_valid;
    logic [HUE_W-1:0]    r1_hue;
    logic [V_W-1:0]      r1_s;
    logic [V_W-1:0]      r1_v0;
    logic [SPAN_W-1:0]   r1_mult;
    logic [SPAN_W-1:0]   r1_span;

    // Stage two registers.
    logic                r2_valid;
    t_work               r2_work;

    logic [SPAN_W-1:0]   span;
    logic [SPAN_W-1:0]   n1_mult;
    logic [HUE_W-1:0]    n1_hue;
    t_sector             n2_sector;
    logic [HUE_W-1:0]    q;
    logic [K_W-1:0]      n2_k;

    // The front holds only when its last stage has an item the queue cannot take.
    assign en      = !(r2_valid && i_fifo_stat.full);
    assign o_stall = !en;
    assign accept  = i_valid && en;
    assign o_push  = r2_valid && en;
    assign o_work  = r2_work;

    assign span    = {1'b0, i_max_ray_length} + SPAN_W'(1);
    assign n1_mult = ({1'b0, i_distance} < span) ? (span - {1'b0, i_distance}) : '0;
    assign n1_hue  = (i_hue >= HUE_360) ? (i_hue - HUE_360) : i_hue;

    always_comb begin
        priority if (r1_hue < HUE_60) begin
            n2_sector = SEC_R2Y;
        end else if (r1_hue < HUE_120) begin
            n2_sector = SEC_Y2G;
        end else if (r1_hue < HUE_180) begin
            n2_sector = SEC_G2C;
        end else if (r1_hue < HUE_240) begin
            n2_sector = SEC_C2B;
        end else if (r1_hue < HUE_300) begin
            n2_sector = SEC_B2M;
        end else begin
            n2_sector = SEC_M2R;
        end
    end

    // Position inside the 120 degree period, folded about 60.
    always_comb begin
        priority if (r1_hue < HUE_120) begin
            q = r1_hue;
        end else if (r1_hue < HUE_240) begin
            q = r1_hue - HUE_120;
        end else begin
            q = r1_hue - HUE_240;
        end
        n2_k = (q >= HUE_60) ? K_W'(HUE_120 - q) : K_W'(q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= accept;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_hue  <= n1_hue;
            r1_s    <= PCT_LUT[i_saturation];
            r1_v0   <= PCT_LUT[i_brightness];
            r1_mult <= n1_mult;
            r1_span <= span;

            r2_work.num         <= NUM_W'(r1_v0 * r1_mult);
            r2_work.span        <= r1_span;
            r2_work.side.s      <= r1_s;
            r2_work.side.sector <= n2_sector;
            r2_work.side.k      <= n2_k;
        end
    end

endmodule

@@ hw/rtl/hdsr_div.sv @@
// Pipelined restoring divider: dimmed value = dividend / span, one quotient bit per stage.
// Depends on hdsr_pkg for widths and the side payload that rides along.
module hdsr_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  hdsr_pkg::t_work            i_work,
    output logic                       o_valid,
    output logic [hdsr_pkg::V_W-1:0]   o_quo,
    output hdsr_pkg::t_side            o_side
);
    import hdsr_pkg::*;

    typedef struct packed {
        logic [SPAN_W-1:0] rem;
        logic [NUM_W-1:0]  w;     // dividend bits shift out, quotient bits shift in
    } t_divst;

    function automatic t_divst div_step(input logic [SPAN_W-1:0] rem,
                                        input logic [NUM_W-1:0]  w,
                                        input logic [SPAN_W-1:0] span);
        t_divst          res;
        logic [SPAN_W:0] t;
        logic            ge;
        t  = {rem, w[NUM_W-1]};
        ge = (t >= {1'b0, span});
        res.rem = ge ? SPAN_W'(t - {1'b0, span}) : SPAN_W'(t);
        res.w   = {w[NUM_W-2:0], ge};
        return res;
    endfunction

    logic [NUM_W-1:0]  r_vld;
    t_divst            r_st   [NUM_W];
    logic [SPAN_W-1:0] r_span [NUM_W];
    t_side             r_side [NUM_W];
    t_divst            n_st   [NUM_W];

    always_comb begin
        n_st[0] = div_step('0, i_work.num, i_work.span);
        for (int j = 1; j < NUM_W; j++) begin
            n_st[j] = div_step(r_st[j-1].rem, r_st[j-1].w, r_span[j-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NUM_W-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_span[0] <= i_work.span;
            r_side[0] <= i_work.side;
            for (int j = 0; j < NUM_W; j++) begin
                r_st[j] <= n_st[j];
            end
            for (int j = 1; j < NUM_W; j++) begin
                r_span[j] <= r_span[j-1];
                r_side[j] <= r_side[j-1];
            end
        end
    end

    assign o_valid = r_vld[NUM_W-1];
    assign o_quo   = r_st[NUM_W-1].w[V_W-1:0];
    assign o_side  = r_side[NUM_W-1];

endmodule

@@ hw/rtl/hdsr_back.sv @@
// Back end: chroma, hue ramp, sector selection, 8-bit scaling and RGB565 packing.
// Depends on hdsr_pkg; fed by hdsr_div, the last stage is the output register.
module hdsr_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [hdsr_pkg::V_W-1:0]     i_v,
    input  hdsr_pkg::t_side              i_side,
    output logic                         o_valid,
    output logic [hdsr_pkg::RGB_W-1:0]   o_rgb565
);
    import hdsr_pkg::*;

    localparam int CV_W  = 2 * V_W;
    localparam int XP_W  = P_W + RECIP_W;
    localparam int SC_W  = V_W + CH8_W;

    logic [5:0]         r_vld;

    // B1: chroma.
    logic [V_W-1:0]     r1_c, r1_v;
    t_sector            r1_sec;
    logic [K_W-1:0]     r1_k;
    // B2: c * k and m.
    logic [P_W-1:0]     r2_p;
    logic [V_W-1:0]     r2_c, r2_m;
    t_sector            r2_sec;
    // B3: estimate of c * k / 60.
    logic [V_W-1:0]     r3_xe;
    logic [P_W-1:0]     r3_p;
    logic [V_W-1:0]     r3_c, r3_m;
    t_sector            r3_sec;
    // B4: corrected x.
    logic [V_W-1:0]     r4_x, r4_c, r4_m;
    t_sector            r4_sec;
    // B5: channels before scaling.
    logic [V_W-1:0]     r5_r, r5_g, r5_b;
    // B6: output register.
    logic [RGB_W-1:0]   r6_rgb;

    logic [CV_W-1:0]    cv;
    logic [XP_W-1:0]    xp;
    logic [P_W-1:0]     rem60;
    logic [V_W-1:0]     n4_x;
    logic [V_W-1:0]     cr, cg, cb;
    logic [CH8_W-1:0]   r8, g8, b8;

    function automatic logic [CH8_W-1:0] chan8(input logic [V_W-1:0] ch);
        logic [SC_W-1:0] sc;
        sc = ({ch, {CH8_W{1'b0}}}) - SC_W'(ch);
        return sc[FRAC_BITS +: CH8_W];
    endfunction

    assign cv = i_v * i_side.s;
    assign xp = r2_p * RECIP60;

    // The reciprocal estimate is low by at most one.
    always_comb begin
        rem60 = r3_p - P_W'(r3_xe * SIXTY_P);
        n4_x  = (rem60 >= SIXTY_P) ? (r3_xe + V_W'(1)) : r3_xe;
    end

    always_comb begin
        unique case (r4_sec)
            SEC_R2Y: begin cr = r4_c; cg = r4_x; cb = '0;   end
            SEC_Y2G: begin cr = r4_x; cg = r4_c; cb = '0;   end
            SEC_G2C: begin cr = '0;   cg = r4_c; cb = r4_x; end
            SEC_C2B: begin cr = '0;   cg = r4_x; cb = r4_c; end
            SEC_B2M: begin cr = r4_x; cg = '0;   cb = r4_c; end
            SEC_M2R: begin cr = r4_c; cg = '0;   cb = r4_x; end
            default: begin cr = '0;   cg = '0;   cb = '0;   end
        endcase
    end

    assign r8 = chan8(r5_r);
    assign g8 = chan8(r5_g);
    assign b8 = chan8(r5_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_v   <= i_v;
            r1_c   <= cv[FRAC_BITS +: V_W];
            r1_sec <= i_side.sector;
            r1_k   <= i_side.k;

            r2_p   <= P_W'(r1_c * r1_k);
            r2_c   <= r1_c;
            r2_m   <= r1_v - r1_c;
            r2_sec <= r1_sec;

            r3_xe  <= V_W'(xp[XP_W-1:P_W]);
            r3_p   <= r2_p;
            r3_c   <= r2_c;
            r3_m   <= r2_m;
            r3_sec <= r2_sec;

            r4_x   <= n4_x;
            r4_c   <= r3_c;
            r4_m   <= r3_m;
            r4_sec <= r3_sec;

            r5_r   <= cr + r4_m;
            r5_g   <= cg + r4_m;
            r5_b   <= cb + r4_m;

            r6_rgb <= {r8[CH8_W-1:3], g8[CH8_W-1:2], b8[CH8_W-1:3]};
        end
    end

    assign o_valid  = r_vld[5];
    assign o_rgb565 = r6_rgb;

endmodule

@@ hw/rtl/hsv_distance_shade_rgb565_top.sv @@
// HSV colour dimmed by distance, converted to RGB565: top level.
// Path: an accepted item passes the front stages, the queue, 26 divider stages and
// 6 back stages before its result is valid; the pipelined dimming divider sets the depth.
// Throughput: one item per cycle while the output is not stalled.
// Reset (i_rst_n low, synchronous) empties every stage and the queue and loads ray length 20.
// Depends on hdsr_pkg, hdsr_front, hdsr_fifo, hdsr_div, hdsr_back and assert_macros.svh.
`include "assert_macros.svh"
module hsv_distance_shade_rgb565_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [hdsr_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [hdsr_pkg::HUE_W-1:0]   i_hue,
    input  logic [hdsr_pkg::PCT_W-1:0]   i_saturation,
    input  logic [hdsr_pkg::PCT_W-1:0]   i_brightness,
    input  logic [hdsr_pkg::DIST_W-1:0]  i_distance,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [hdsr_pkg::RGB_W-1:0]   o_rgb565
);
    import hdsr_pkg::*;

    // The ray length register. The user must write it only while the block is idle (the block
    // does not enforce this), so the front reads it directly when it forms the span L+1.
    logic [CFG_W-1:0] r_max_ray_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_ray_length <= MAX_RAY_RESET;
        end else if (i_cfg_we) begin
            r_max_ray_length <= i_cfg_wdata;
        end
    end

    // The front stalls the input only when its last stage holds an item and the
    // queue is full. The back advances as one pipeline whenever its output
    // register is empty or being taken, so the two sides never wait on each other
    // combinationally: the queue's registered full and empty flags are the only link.
    t_fifo_stat       fifo_stat;
    t_work            push_work;
    t_work            pop_work;
    logic             fifo_push;
    logic             fifo_pop;
    logic             en_b;

    logic             div_valid;
    logic [V_W-1:0]   div_quo;
    t_side            div_side;

    hdsr_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_in_valid),
        .o_stall          (o_in_stall),
        .i_hue            (i_hue),
        .i_saturation     (i_saturation),
        .i_brightness     (i_brightness),
        .i_distance       (i_distance),
        .i_max_ray_length (r_max_ray_length),
        .i_fifo_stat      (fifo_stat),
        .o_push           (fifo_push),
        .o_work           (push_work)
    );

    hdsr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fifo_push),
        .i_data  (push_work),
        .i_pop   (fifo_pop),
        .o_data  (pop_work),
        .o_stat  (fifo_stat)
    );

    assign en_b     = !(o_out_valid && i_out_stall);
    assign fifo_pop = en_b && !fifo_stat.empty;

    // The divider works out v0 * (L+1-d) / (L+1); a zero dividend covers the
    // case of a distance at or beyond L+1.
    hdsr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en_b),
        .i_valid (fifo_pop),
        .i_work  (pop_work),
        .o_valid (div_valid),
        .o_quo   (div_quo),
        .o_side  (div_side)
    );

    hdsr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en_b),
        .i_valid  (div_valid),
        .i_v      (div_quo),
        .i_side   (div_side),
        .o_valid  (o_out_valid),
        .o_rgb565 (o_rgb565)
    );

    // The queue is never written when full nor read when empty.
    `ASSERT_NEVER(a_fifo_overflow, i_clk, i_rst_n, fifo_push && fifo_stat.full, "push into full queue")
    `ASSERT_NEVER(a_fifo_underflow, i_clk, i_rst_n, fifo_pop && fifo_stat.empty, "pop from empty queue")
    // A new result only appears when the back pipeline has just advanced.
    `ASSERT_PROP(a_out_rise_on_advance, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(en_b), "result appeared while back held")

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the distance-dimmed HSV to RGB565 shading block.
// Depends on hdsr_pkg and the hsv_distance_shade_rgb565_top RTL; needs no files or arguments.
// A scoreboard class predicts every packed color and checks each result in order.
module testbench;

    localparam int HOLD_CYCLES = 150;   // long receiver hold-off, well past the pipe depth
    localparam int SETTLE      = 45;    // margin beyond the pipeline latency
    localparam int IDLE_LIMIT  = 4000;  // cycles with no handshake on either side

    // The scoreboard holds the ray length last written and one predicted color per
    // accepted item, oldest first.
    class shade_scoreboard;
        logic [hdsr_pkg::CFG_W-1:0] ray_len;
        logic [hdsr_pkg::RGB_W-1:0] expected_rgb[$];
        int errors;
        int colors_in;
        int colors_out;

        function new();
            ray_len    = hdsr_pkg::MAX_RAY_RESET;
            errors     = 0;
            colors_in  = 0;
            colors_out = 0;
        endfunction

        // Dim the value by distance, run the six-sector conversion in fixed point
        // with 16 fraction bits, scale each channel to 8 bits and pack as 5-6-5.
        function logic [hdsr_pkg::RGB_W-1:0] shade_color(
            logic [hdsr_pkg::HUE_W-1:0]  hue,
            logic [hdsr_pkg::PCT_W-1:0]  sat,
            logic [hdsr_pkg::PCT_W-1:0]  bri,
            logic [hdsr_pkg::DIST_W-1:0] ray_dist
        );
            longint unsigned unity, deg, sp, bp, span;
            longint unsigned s, v, c, m, q, k, x, r, g, b;
            hdsr_pkg::t_sector sec;
            logic [7:0] r8, g8, b8;
            unity = 64'd1 << hdsr_pkg::FRAC_BITS;
            deg   = hue;
            if (deg >= 360) begin
                deg = deg - 360;
            end
            sp = (sat > 100) ? 100 : sat;
            bp = (bri > 100) ? 100 : bri;
            s  = sp * unity / 100;
            v  = bp * unity / 100;
            span = longint'(ray_len) + 1;
            if (ray_dist < span) begin
                v = v * (span - ray_dist) / span;
            end else begin
                v = 0;
            end
            c = (s * v) >> hdsr_pkg::FRAC_BITS;
            m = v - c;
            q = deg % 120;
            k = (q >= 60) ? (120 - q) : q;
            x = c * k / 60;
            sec = hdsr_pkg::t_sector'(3'(deg / 60));
            case (sec)
                hdsr_pkg::SEC_R2Y: begin r = c; g = x; b = 0; end
                hdsr_pkg::SEC_Y2G: begin r = x; g = c; b = 0; end
                hdsr_pkg::SEC_G2C: begin r = 0; g = c; b = x; end
                hdsr_pkg::SEC_C2B: begin r = 0; g = x; b = c; end
                hdsr_pkg::SEC_B2M: begin r = x; g = 0; b = c; end
                default:           begin r = c; g = 0; b = x; end
            endcase
            r8 = 8'(((r + m) * 255) >> hdsr_pkg::FRAC_BITS);
            g8 = 8'(((g + m) * 255) >> hdsr_pkg::FRAC_BITS);
            b8 = 8'(((b + m) * 255) >> hdsr_pkg::FRAC_BITS);
            return {r8[7:3], g8[7:2], b8[7:3]};
        endfunction

        function void note_color(
            logic [hdsr_pkg::HUE_W-1:0]  hue,
            logic [hdsr_pkg::PCT_W-1:0]  sat,
            logic [hdsr_pkg::PCT_W-1:0]  bri,
            logic [hdsr_pkg::DIST_W-1:0] ray_dist
        );
            expected_rgb.push_back(shade_color(hue, sat, bri, ray_dist));
            colors_in++;
        endfunction

        function void check_pixel(logic [hdsr_pkg::RGB_W-1:0] got);
            logic [hdsr_pkg::RGB_W-1:0] want;
            colors_out++;
            if (expected_rgb.size() == 0) begin
                $error("rgb565 result %h arrived with no color pending", got);
                errors++;
            end else begin
                want = expected_rgb.pop_front();
                if (got !== want) begin
                    $error("rgb565 mismatch: expected %h, actual %h", want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [hdsr_pkg::CFG_W-1:0]   i_cfg_wdata;
    logic                         i_in_valid;
    logic                         o_in_stall;
    logic [hdsr_pkg::HUE_W-1:0]   i_hue;
    logic [hdsr_pkg::PCT_W-1:0]   i_saturation;
    logic [hdsr_pkg::PCT_W-1:0]   i_brightness;
    logic [hdsr_pkg::DIST_W-1:0]  i_distance;
    logic                         o_out_valid;
    logic                         i_out_stall;
    logic [hdsr_pkg::RGB_W-1:0]   o_rgb565;

    shade_scoreboard sb;

    // Knobs that the main sequence turns per phase. The receiver process reads rx_gaps and hold_request.
    logic tx_gaps;
    logic rx_gaps;
    logic hold_request;
    int   settings_used;
    int   idle_cycles;

    hsv_distance_shade_rgb565_top DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .i_distance   (i_distance),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_rgb565     (o_rgb565)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Gap lengths for both sides: mostly from the shortest range, sometimes from a middle one,
    // and now and then a long one that lets the pipeline run dry or fill up.
    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            return $urandom_range(1, 2);
        end else if (pick < 95) begin
            return $urandom_range(3, 8);
        end
        return $urandom_range(20, 60);
    endfunction

    // Input and output monitors. All inputs change at the falling edge, so the
    // values seen here at the rising edge are the ones the block sampled.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            sb.note_color(i_hue, i_saturation, i_brightness, i_distance);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_pixel(o_rgb565);
        end
    end

    // Watchdog: a run that stops moving on both sides for too long is a failure.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver side. A hold request stalls the output for a fixed stretch that
    // this process counts itself; otherwise random stalls come in when enabled.
    initial begin : rx_side
        int n;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_stall  = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_out_stall  = 1'b0;
            end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
                n = gap_len();
                i_out_stall = 1'b1;
                repeat (n) @(negedge i_clk);
                i_out_stall = 1'b0;
            end
        end
    end

    // Lower the input valid for a gap whose length is given by n.
    task automatic pause_sender(input int n);
        repeat (n) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
    endtask

    // Offer one item and hold it until the block takes it. Valid stays high into
    // the next item when no gap follows, so it is never dropped and raised in one step.
    task automatic send_color(
        input logic [hdsr_pkg::HUE_W-1:0]  hue,
        input logic [hdsr_pkg::PCT_W-1:0]  sat,
        input logic [hdsr_pkg::PCT_W-1:0]  bri,
        input logic [hdsr_pkg::DIST_W-1:0] ray_dist
    );
        @(negedge i_clk);
        i_in_valid   = 1'b1;
        i_hue        = hue;
        i_saturation = sat;
        i_brightness = bri;
        i_distance   = ray_dist;
        do @(posedge i_clk); while (o_in_stall);
        if (tx_gaps && $urandom_range(0, 2) == 0) begin
            pause_sender(gap_len());
        end
    endtask

    // Random item. Most fields stay in their documented range; a share goes past
    // it so that hue wrap and percent clamping are hit. Distances mostly land in
    // the dimming slope, just past its end, or anywhere in the field.
    task automatic send_random_color();
        logic [hdsr_pkg::HUE_W-1:0]  hue;
        logic [hdsr_pkg::PCT_W-1:0]  sat;
        logic [hdsr_pkg::PCT_W-1:0]  bri;
        logic [hdsr_pkg::DIST_W-1:0] ray_dist;
        int reach;
        hue = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(360, 511))
                                          : 9'($urandom_range(0, 359));
        sat = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(101, 127))
                                          : 7'($urandom_range(0, 100));
        bri = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(101, 127))
                                          : 7'($urandom_range(0, 100));
        reach = (int'(sb.ray_len) + 1 > 255) ? 255 : int'(sb.ray_len) + 1;
        if ($urandom_range(0, 4) == 0) begin
            ray_dist = 8'($urandom_range(0, 255));
        end else begin
            ray_dist = 8'($urandom_range(0, reach));
        end
        send_color(hue, sat, bri, ray_dist);
    endtask

    // Stop offering items and wait until every predicted color has come back.
    task automatic drain();
        pause_sender(1);
        while (sb.expected_rgb.size() != 0) @(negedge i_clk);
    endtask

    // The block is idle whenever nothing is pending, since every item yields one
    // color, so the ray length can be rewritten right after a drain.
    task automatic write_ray_length(input logic [hdsr_pkg::CFG_W-1:0] len);
        drain();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = len;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        sb.ray_len  = len;
        settings_used++;
    endtask

    task automatic send_random_batch(input int count);
        repeat (count) send_random_color();
    endtask

    initial begin
        sb            = new();
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        i_in_valid    = 1'b0;
        i_hue         = '0;
        i_saturation  = '0;
        i_brightness  = '0;
        i_distance    = '0;
        tx_gaps       = 1'b0;
        rx_gaps       = 1'b0;
        hold_request  = 1'b0;
        settings_used = 1;
        idle_cycles   = 0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part at the reset ray length of 20. Fully saturated, full
        // brightness colors on both sides of every sector boundary.
        send_color(9'd0,   7'd100, 7'd100, 8'd0);
        send_color(9'd59,  7'd100, 7'd100, 8'd0);
        send_color(9'd60,  7'd100, 7'd100, 8'd0);
        send_color(9'd119, 7'd100, 7'd100, 8'd0);
        send_color(9'd120, 7'd100, 7'd100, 8'd0);
        send_color(9'd179, 7'd100, 7'd100, 8'd0);
        send_color(9'd180, 7'd100, 7'd100, 8'd0);
        send_color(9'd239, 7'd100, 7'd100, 8'd0);
        send_color(9'd240, 7'd100, 7'd100, 8'd0);
        send_color(9'd299, 7'd100, 7'd100, 8'd0);
        send_color(9'd300, 7'd100, 7'd100, 8'd0);
        send_color(9'd359, 7'd100, 7'd100, 8'd0);
        // Hues of 360 and above wrap around; the all-ones hue is the far end.
        send_color(9'd360, 7'd100, 7'd100, 8'd0);
        send_color(9'd511, 7'd80,  7'd90,  8'd3);
        // Percentages above 100 clamp; zero saturation gives gray, zero value black.
        send_color(9'd200, 7'd127, 7'd127, 8'd0);
        send_color(9'd45,  7'd0,   7'd100, 8'd0);
        send_color(9'd45,  7'd100, 7'd0,   8'd0);
        send_color(9'd170, 7'd0,   7'd0,   8'd0);
        // Dimming: last distance before black, the first one that is black, the
        // farthest distance, and a midpoint.
        send_color(9'd90,  7'd60,  7'd100, 8'd20);
        send_color(9'd90,  7'd60,  7'd100, 8'd21);
        send_color(9'd330, 7'd100, 7'd100, 8'd255);
        send_color(9'd270, 7'd50,  7'd75,  8'd10);

        // Random items at the reset setting, idling on both sides.
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        send_random_batch(60);

        // Longest ray, a long stretch with no idling on either side.
        write_ray_length(8'd255);
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        send_random_batch(60);

        // Ray length zero: any nonzero distance turns the color black.
        write_ray_length(8'd0);
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        send_color(9'd10, 7'd100, 7'd100, 8'd0);
        send_color(9'd10, 7'd100, 7'd100, 8'd1);
        send_random_batch(40);

        // Ray length one. The receiver holds off long enough for the pipeline
        // and its queue to fill while the sender keeps offering items back to back.
        write_ray_length(8'd1);
        send_random_batch(20);
        tx_gaps      = 1'b0;
        hold_request = 1'b1;
        send_random_batch(60);
        tx_gaps = 1'b1;

        // A random mid-range ray; halfway through, the sender waits for the
        // pipeline to run empty before carrying on.
        write_ray_length(8'($urandom_range(2, 254)));
        send_random_batch(30);
        drain();
        send_random_batch(30);

        // One more random setting, anywhere in the register.
        write_ray_length(8'($urandom_range(0, 255)));
        send_random_batch(60);

        drain();
        repeat (SETTLE) @(negedge i_clk);

        $display("Run covered %0d items and %0d results across %0d ray-length settings,",
                 sb.colors_in, sb.colors_out, settings_used);
        $display("including every hue sector, wrapped hues, clamped percentages and black.");
        if (sb.errors == 0 && sb.expected_rgb.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
